/* sv/bbu_pkg.sv */
// Package: shared types, register indexes and reset values for the bit-bang UART.
package bbu_pkg;

  localparam int unsigned CfgIdxW = 8;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_TX_BIT_TIME   = 8'd0,
    CFG_RX_BIT_TIME   = 8'd1,
    CFG_RX_FIRST_TIME = 8'd2,
    CFG_IDLE_POLL     = 8'd3
  } cfg_idx_t;

  localparam logic [7:0] TxBitTimeRst   = 8'd51;
  localparam logic [7:0] RxBitTimeRst   = 8'd50;
  localparam logic [7:0] RxFirstTimeRst = 8'd75;
  localparam logic [7:0] IdlePollRst    = 8'd2;

  localparam logic [3:0] PosStart = 4'd0;
  localparam logic [3:0] PosIdle  = 4'd0;
  localparam logic [3:0] PosFirst = 4'd1;
  localparam logic [3:0] PosLast  = 4'd8;
  localparam logic [3:0] PosStop  = 4'd9;

  typedef struct packed {
    logic [7:0] tx_bit_time;
    logic [7:0] rx_bit_time;
    logic [7:0] rx_first_sample_time;
    logic [7:0] idle_poll_time;
  } cfg_regs_t;

  typedef struct packed {
    logic tx_line;
    logic tx_busy;
    logic tx_done;
  } tx_status_t;

  typedef struct packed {
    logic       rx_busy;
    logic       rx_done;
    logic       rx_expired;
    logic [7:0] rx_byte;
  } rx_status_t;

  // zero time acts as one tick
  function automatic logic [7:0] at_least_one(input logic [7:0] t);
    at_least_one = (t == 8'd0) ? 8'd1 : t;
  endfunction

endpackage

/* sv/bbu_if.sv */
// Interfaces: tick input channel, result channel and register write channel.
interface bbu_in_if;
  logic        valid;
  logic        ready;
  logic        tx_start;
  logic [7:0]  tx_value;
  logic        rx_start;
  logic [15:0] rx_poll_limit;
  logic        rx_line;

  modport source (output valid, tx_start, tx_value, rx_start, rx_poll_limit, rx_line,
                  input ready);
  modport sink (input valid, tx_start, tx_value, rx_start, rx_poll_limit, rx_line,
                output ready);
endinterface

interface bbu_out_if;
  logic       valid;
  logic       ready;
  logic       tx_line;
  logic       tx_busy;
  logic       tx_done;
  logic       rx_busy;
  logic       rx_done;
  logic       rx_expired;
  logic [7:0] rx_byte;

  modport source (output valid, tx_line, tx_busy, tx_done, rx_busy, rx_done, rx_expired,
                  rx_byte, input ready);
  modport sink (input valid, tx_line, tx_busy, tx_done, rx_busy, rx_done, rx_expired,
                rx_byte, output ready);
endinterface

interface bbu_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] index;
  logic [7:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

/* sv/bbu_tx.sv */
// Transmitter: 8N1 bit sequencer advanced once per accepted tick.
module bbu_tx (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               tick,
  input  logic [7:0]         bit_time,
  input  logic               tx_start,
  input  logic [7:0]         tx_value,
  output bbu_pkg::tx_status_t status
);
  import bbu_pkg::*;

  logic [3:0] pos_r, pos_nxt;
  logic [7:0] hold_r, hold_nxt;
  logic [7:0] wait_r, wait_nxt;
  logic       active_r, active_nxt;
  logic [7:0] wait_dec;
  logic [2:0] bit_idx;
  logic       done;

  assign wait_dec = wait_r - 8'd1;

  always_comb begin
    pos_nxt    = pos_r;
    hold_nxt   = hold_r;
    wait_nxt   = wait_r;
    active_nxt = active_r;
    done       = 1'b0;
    if (!active_r) begin
      if (tx_start) begin
        hold_nxt   = tx_value;
        active_nxt = 1'b1;
        pos_nxt    = PosStart;
        wait_nxt   = at_least_one(bit_time);
      end
    end else begin
      wait_nxt = wait_dec;
      if (wait_dec == 8'd0) begin
        if (pos_r >= PosStop) begin
          active_nxt = 1'b0;
          pos_nxt    = PosStart;
          done       = 1'b1;
        end else begin
          pos_nxt  = pos_r + 4'd1;
          wait_nxt = at_least_one(bit_time);
        end
      end
    end
  end

  assign bit_idx = 3'(pos_nxt - 4'd1);

  always_comb begin
    status.tx_line = 1'b1;
    if (active_nxt) begin
      if (pos_nxt == PosStart) status.tx_line = 1'b0;
      else if (pos_nxt <= PosLast) status.tx_line = hold_nxt[bit_idx];
    end
    status.tx_busy = active_nxt;
    status.tx_done = done;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= PosStart;
      hold_r   <= 8'd0;
      wait_r   <= 8'd0;
      active_r <= 1'b0;
    end else if (tick) begin
      pos_r    <= pos_nxt;
      hold_r   <= hold_nxt;
      wait_r   <= wait_nxt;
      active_r <= active_nxt;
    end
  end

endmodule

/* sv/bbu_rx.sv */
// Receiver: line poller with sample timing and poll-count timeout.
module bbu_rx (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               tick,
  input  bbu_pkg::cfg_regs_t cfg,
  input  logic               rx_start,
  input  logic [15:0]        rx_poll_limit,
  input  logic               rx_line,
  output bbu_pkg::rx_status_t status
);
  import bbu_pkg::*;

  logic [3:0]  pos_r, pos_nxt;
  logic [7:0]  value_r, value_nxt;
  logic [7:0]  wait_r, wait_nxt;
  logic [16:0] count_r, count_nxt;
  logic [15:0] limit_r, limit_nxt;
  logic        active_r, active_nxt;
  logic        over_r, over_nxt;
  logic [7:0]  wait_dec;
  logic [2:0]  bit_idx;
  logic        do_poll;
  logic        done, timeout;
  logic [7:0]  byte_out;

  assign wait_dec = wait_r - 8'd1;
  assign bit_idx  = 3'(pos_r - 4'd1);

  always_comb begin
    pos_nxt    = pos_r;
    value_nxt  = value_r;
    wait_nxt   = wait_r;
    count_nxt  = count_r;
    limit_nxt  = limit_r;
    active_nxt = active_r;
    over_nxt   = over_r;
    do_poll    = 1'b0;
    done       = 1'b0;
    timeout    = 1'b0;
    byte_out   = 8'd0;
    if (!active_r) begin
      if (rx_start) begin
        limit_nxt  = rx_poll_limit;
        count_nxt  = 17'd0;
        active_nxt = 1'b1;
        over_nxt   = 1'b0;
        do_poll    = 1'b1;
      end
    end else begin
      wait_nxt = wait_dec;
      if (wait_dec == 8'd0) begin
        if (over_r) begin
          over_nxt   = 1'b0;
          active_nxt = 1'b0;
          done       = 1'b1;
          byte_out   = value_r;
        end else if (count_r > {1'b0, limit_r}) begin
          active_nxt = 1'b0;
          done       = 1'b1;
          timeout    = 1'b1;
        end else begin
          count_nxt = count_r + 17'd1;
          do_poll   = 1'b1;
        end
      end
    end
    if (do_poll) begin
      if (pos_r == PosIdle) begin
        if (!rx_line) begin
          pos_nxt  = PosFirst;
          wait_nxt = at_least_one(cfg.rx_first_sample_time);
        end else begin
          wait_nxt = at_least_one(cfg.idle_poll_time);
        end
      end else if (pos_r <= PosLast) begin
        value_nxt[bit_idx] = rx_line;
        pos_nxt            = pos_r + 4'd1;
        wait_nxt           = at_least_one(cfg.rx_bit_time);
      end else begin
        pos_nxt  = PosIdle;
        over_nxt = 1'b1;
        wait_nxt = at_least_one(cfg.rx_bit_time);
      end
    end
  end

  assign status.rx_busy    = active_nxt;
  assign status.rx_done    = done;
  assign status.rx_expired = timeout;
  assign status.rx_byte    = byte_out;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= PosIdle;
      value_r  <= 8'd0;
      wait_r   <= 8'd0;
      count_r  <= 17'd0;
      limit_r  <= 16'd0;
      active_r <= 1'b0;
      over_r   <= 1'b0;
    end else if (tick) begin
      pos_r    <= pos_nxt;
      value_r  <= value_nxt;
      wait_r   <= wait_nxt;
      count_r  <= count_nxt;
      limit_r  <= limit_nxt;
      active_r <= active_nxt;
      over_r   <= over_nxt;
    end
  end

endmodule

/* sv/bitbang_uart_8n1_with_poll_timeout.sv */
// Top level: register bank, transmitter, receiver and result register.
// The result of an accepted tick beat is registered and offered as its result beat in the next cycle.
// Throughput: one tick beat per cycle while the result side takes beats.
// The result register stalls the input only when it is full and not taken.
// Reset (rst_n low, synchronous): both sides idle, timing registers at
// 51/50/75/2, counters and held bytes zero, result register empty.
module bitbang_uart_8n1_with_poll_timeout (
  input  logic  clk,
  input  logic  rst_n,
  bbu_in_if.sink     in_ch,
  bbu_out_if.source  out_ch,
  bbu_cfg_if.sink    cfg_ch
);
  import bbu_pkg::*;

  cfg_regs_t  cfg_r;
  tx_status_t tx_st;
  rx_status_t rx_st;
  tx_status_t tx_out_r;
  rx_status_t rx_out_r;
  logic       out_valid_r, out_valid_nxt;
  logic       tick;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.tx_bit_time          <= TxBitTimeRst;
      cfg_r.rx_bit_time          <= RxBitTimeRst;
      cfg_r.rx_first_sample_time <= RxFirstTimeRst;
      cfg_r.idle_poll_time       <= IdlePollRst;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        CFG_TX_BIT_TIME:   cfg_r.tx_bit_time          <= cfg_ch.data;
        CFG_RX_BIT_TIME:   cfg_r.rx_bit_time          <= cfg_ch.data;
        CFG_RX_FIRST_TIME: cfg_r.rx_first_sample_time <= cfg_ch.data;
        CFG_IDLE_POLL:     cfg_r.idle_poll_time       <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  assign in_ch.ready   = !out_valid_r || out_ch.ready;
  assign tick          = in_ch.valid && in_ch.ready;
  assign out_valid_nxt = tick || (out_valid_r && !out_ch.ready);

  bbu_tx u_tx (
    .clk      (clk),
    .rst_n    (rst_n),
    .tick     (tick),
    .bit_time (cfg_r.tx_bit_time),
    .tx_start (in_ch.tx_start),
    .tx_value (in_ch.tx_value),
    .status   (tx_st)
  );

  bbu_rx u_rx (
    .clk           (clk),
    .rst_n         (rst_n),
    .tick          (tick),
    .cfg           (cfg_r),
    .rx_start      (in_ch.rx_start),
    .rx_poll_limit (in_ch.rx_poll_limit),
    .rx_line       (in_ch.rx_line),
    .status        (rx_st)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    if (tick) begin
      tx_out_r <= tx_st;
      rx_out_r <= rx_st;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.tx_line    = tx_out_r.tx_line;
  assign out_ch.tx_busy    = tx_out_r.tx_busy;
  assign out_ch.tx_done    = tx_out_r.tx_done;
  assign out_ch.rx_busy    = rx_out_r.rx_busy;
  assign out_ch.rx_done    = rx_out_r.rx_done;
  assign out_ch.rx_expired = rx_out_r.rx_expired;
  assign out_ch.rx_byte    = rx_out_r.rx_byte;

  a_tick_gives_beat: assert property (@(posedge clk) disable iff (!rst_n)
    tick |=> out_valid_r)
    else $error("accepted tick produced no result beat");

  a_tx_idle_high: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !tx_out_r.tx_busy) |-> tx_out_r.tx_line)
    else $error("tx line low while transmitter idle");

  a_tx_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && tx_out_r.tx_done) |-> !tx_out_r.tx_busy)
    else $error("tx done while still busy");

  a_rx_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && rx_out_r.rx_done) |-> !rx_out_r.rx_busy)
    else $error("rx done while still armed");

  a_rx_expired_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (rx_out_r.rx_expired || !rx_out_r.rx_done)) |->
      (rx_out_r.rx_byte == 8'd0))
    else $error("rx byte nonzero outside a good receive");

endmodule

/* verif/tb_bitbang_uart_8n1_with_poll_timeout.sv */
`timescale 1ns / 1ps
// Testbench: streams timing ticks through the bit-bang UART and checks each status beat.
module tb_bitbang_uart_8n1_with_poll_timeout;
  import bbu_pkg::*;

  typedef struct packed {
    logic        tx_start;
    logic [7:0]  tx_value;
    logic        rx_start;
    logic [15:0] rx_poll_limit;
    logic        rx_line;
  } tick_t;

  typedef struct packed {
    tx_status_t tx;
    rx_status_t rx;
  } line_status_t;

  typedef enum logic {ROW_TICK, ROW_REG} row_kind_t;

  typedef struct {
    row_kind_t    kind;
    cfg_idx_t     reg_idx;
    logic [7:0]   reg_val;
    tick_t        tk;
    bit           typed;
    line_status_t want;
  } dir_row_t;

  localparam tick_t NO_TICK = '0;
  localparam line_status_t ST_QUIET =
    '{'{1'b1, 1'b0, 1'b0}, '{1'b0, 1'b0, 1'b0, 8'h00}};
  localparam line_status_t ST_RX_ARMED =
    '{'{1'b1, 1'b0, 1'b0}, '{1'b1, 1'b0, 1'b0, 8'h00}};
  localparam line_status_t ST_RX_TIMEOUT =
    '{'{1'b1, 1'b0, 1'b0}, '{1'b0, 1'b1, 1'b1, 8'h00}};

  // reset timing: limit-0 timeout, starts ignored while armed and on the done beat;
  // then zero/extreme registers, a partial byte that times out and resumes, tx busy/done starts
  dir_row_t directed_rows [23] = '{
    '{ROW_TICK, CFG_TX_BIT_TIME, 8'h00, '{1'b0, 8'h00, 1'b0, 16'h0000, 1'b1}, 1'b1, ST_QUIET},
    '{ROW_TICK, CFG_TX_BIT_TIME, 8'h00, '{1'b0, 8'hFF, 1'b1, 16'h0000, 1'b1}, 1'b1, ST_RX_ARMED},
    '{ROW_TICK, CFG_TX_BIT_TIME, 8'h00, '{1'b0, 8'h00, 1'b1, 16'hFFFF, 1'b0}, 1'b1, ST_RX_ARMED},
    '{ROW_TICK, CFG_TX_BIT_TIME, 8'h00, '{1'b0, 8'h00, 1'b0, 16'h0000, 1'b1}, 1'b1, ST_RX_ARMED},
    '{ROW_TICK, CFG_TX_BIT_TIME, 8'h00, '{1'b0, 8'h00, 1'b0, 16'h0000, 1'b1}, 1'b1, ST_RX_ARMED},
    '{ROW_TICK, CFG_TX_BIT_TIME, 8'h00, '{1'b0, 8'h00, 1'b1, 16'hFFFF, 1'b1}, 1'b1,
      ST_RX_TIMEOUT},
    '{ROW_REG, CFG_TX_BIT_TIME, 8'd1, NO_TICK, 1'b0, ST_QUIET},
    '{ROW_REG, CFG_RX_BIT_TIME, 8'd1, NO_TICK, 1'b0, ST_QUIET},
    '{ROW_REG, CFG_RX_FIRST_TIME, 8'd0, NO_TICK, 1'b0, ST_QUIET},
    '{ROW_REG, CFG_IDLE_POLL, 8'd255, NO_TICK, 1'b0, ST_QUIET},
    '{ROW_TICK, CFG_TX_BIT_TIME, 8'h00, '{1'b1, 8'hFF, 1'b1, 16'h0003, 1'b0}, 1'b0, ST_QUIET},
    '{ROW_TICK, CFG_TX_BIT_TIME, 8'h00, '{1'b1, 8'h00, 1'b0, 16'h0000, 1'b1}, 1'b0, ST_QUIET},
    '{ROW_TICK, CFG_TX_BIT_TIME, 8'h00, '{1'b0, 8'h00, 1'b0, 16'h0000, 1'b0}, 1'b0, ST_QUIET},
    '{ROW_TICK, CFG_TX_BIT_TIME, 8'h00, '{1'b0, 8'h00, 1'b0, 16'h0000, 1'b1}, 1'b0, ST_QUIET},
    '{ROW_TICK, CFG_TX_BIT_TIME, 8'h00, '{1'b0, 8'h00, 1'b0, 16'h0000, 1'b1}, 1'b0, ST_QUIET},
    '{ROW_TICK, CFG_TX_BIT_TIME, 8'h00, '{1'b0, 8'h00, 1'b0, 16'h0000, 1'b0}, 1'b0, ST_QUIET},
    '{ROW_TICK, CFG_TX_BIT_TIME, 8'h00, '{1'b0, 8'h00, 1'b1, 16'hFFFF, 1'b1}, 1'b0, ST_QUIET},
    '{ROW_TICK, CFG_TX_BIT_TIME, 8'h00, '{1'b0, 8'h00, 1'b0, 16'h0000, 1'b0}, 1'b0, ST_QUIET},
    '{ROW_TICK, CFG_TX_BIT_TIME, 8'h00, '{1'b0, 8'h00, 1'b0, 16'h0000, 1'b1}, 1'b0, ST_QUIET},
    '{ROW_TICK, CFG_TX_BIT_TIME, 8'h00, '{1'b0, 8'h00, 1'b0, 16'h0000, 1'b0}, 1'b0, ST_QUIET},
    '{ROW_TICK, CFG_TX_BIT_TIME, 8'h00, '{1'b1, 8'h5A, 1'b0, 16'h0000, 1'b1}, 1'b0, ST_QUIET},
    '{ROW_TICK, CFG_TX_BIT_TIME, 8'h00, '{1'b1, 8'h81, 1'b0, 16'h0000, 1'b1}, 1'b0, ST_QUIET},
    '{ROW_TICK, CFG_TX_BIT_TIME, 8'h00, '{1'b0, 8'h00, 1'b0, 16'h0000, 1'b1}, 1'b0, ST_QUIET}
  };

  logic clk = 1'b0;
  logic rst_n;
  logic sink_ready = 1'b0;

  bbu_in_if  in_if ();
  bbu_out_if out_if ();
  bbu_cfg_if cfg_if ();

  assign out_if.ready = sink_ready;

  bitbang_uart_8n1_with_poll_timeout uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if),
    .cfg_ch (cfg_if)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // UART state as the block should hold it; registers kept with zero already read as one
  cfg_regs_t   model_regs;
  logic [3:0]  tx_pos;
  logic [7:0]  tx_hold;
  logic [7:0]  tx_wait;
  logic        tx_act;
  logic [3:0]  rx_pos;
  logic [7:0]  rx_val;
  logic [7:0]  rx_wait;
  logic [16:0] rx_polls;
  logic [15:0] rx_lim;
  logic        rx_act;
  logic        rx_stop_seen;
  logic        last_tx_line;

  line_status_t pending_status [$];
  logic         line_q [$];

  bit          idle_on;
  bit          loopback;
  int unsigned stall_left = 0;
  int unsigned mismatches = 0;
  int unsigned beats_seen = 0;
  int unsigned ticks_sent = 0;
  int unsigned settings_used = 2;
  int unsigned bytes_sent = 0;
  int unsigned bytes_received = 0;
  int unsigned rx_timeouts = 0;

  task automatic reset_model();
    model_regs = '{TxBitTimeRst, RxBitTimeRst, RxFirstTimeRst, IdlePollRst};
    tx_pos = PosStart;
    tx_hold = 8'h00;
    tx_wait = 8'h00;
    tx_act = 1'b0;
    rx_pos = PosIdle;
    rx_val = 8'h00;
    rx_wait = 8'h00;
    rx_polls = '0;
    rx_lim = 16'h0000;
    rx_act = 1'b0;
    rx_stop_seen = 1'b0;
    last_tx_line = 1'b1;
  endtask

  function automatic void rx_take_poll(input logic line);
    if (rx_pos == PosIdle) begin
      if (!line) begin
        rx_pos = PosFirst;
        rx_wait = model_regs.rx_first_sample_time;
      end else begin
        rx_wait = model_regs.idle_poll_time;
      end
    end else if (rx_pos <= PosLast) begin
      rx_val[3'(rx_pos - 4'd1)] = line;
      rx_pos = rx_pos + 4'd1;
      rx_wait = model_regs.rx_bit_time;
    end else begin
      rx_pos = PosIdle;
      rx_stop_seen = 1'b1;
      rx_wait = model_regs.rx_bit_time;
    end
  endfunction

  function automatic line_status_t advance_tick(input tick_t tk);
    line_status_t st;
    st = ST_QUIET;
    if (!tx_act) begin
      if (tk.tx_start) begin
        tx_hold = tk.tx_value;
        tx_act = 1'b1;
        tx_pos = PosStart;
        tx_wait = model_regs.tx_bit_time;
      end
    end else begin
      tx_wait = tx_wait - 8'd1;
      if (tx_wait == 8'd0) begin
        if (tx_pos >= PosStop) begin
          tx_act = 1'b0;
          tx_pos = PosStart;
          st.tx.tx_done = 1'b1;
          bytes_sent++;
        end else begin
          tx_pos = tx_pos + 4'd1;
          tx_wait = model_regs.tx_bit_time;
        end
      end
    end
    if (tx_act) begin
      if (tx_pos == PosStart) st.tx.tx_line = 1'b0;
      else if (tx_pos <= PosLast) st.tx.tx_line = tx_hold[3'(tx_pos - 4'd1)];
    end
    st.tx.tx_busy = tx_act;
    last_tx_line = st.tx.tx_line;

    if (!rx_act) begin
      if (tk.rx_start) begin
        rx_lim = tk.rx_poll_limit;
        rx_polls = '0;
        rx_act = 1'b1;
        rx_stop_seen = 1'b0;
        rx_take_poll(tk.rx_line);
      end
    end else begin
      rx_wait = rx_wait - 8'd1;
      if (rx_wait == 8'd0) begin
        if (rx_stop_seen) begin
          rx_stop_seen = 1'b0;
          rx_act = 1'b0;
          st.rx.rx_done = 1'b1;
          st.rx.rx_byte = rx_val;
          bytes_received++;
        end else if (rx_polls > {1'b0, rx_lim}) begin
          rx_act = 1'b0;
          st.rx.rx_done = 1'b1;
          st.rx.rx_expired = 1'b1;
          rx_timeouts++;
        end else begin
          rx_polls = rx_polls + 17'd1;
          rx_take_poll(tk.rx_line);
        end
      end
    end
    st.rx.rx_busy = rx_act;
    return st;
  endfunction

  function automatic void cmp_field(input string name, input logic [7:0] want,
                                    input logic [7:0] seen);
    if (want !== seen) begin
      if (mismatches < 10)
        $display("beat %0d: %s expected %0h, got %0h", beats_seen, name, want, seen);
      mismatches++;
    end
  endfunction

  task automatic check_beat();
    line_status_t want;
    if (pending_status.size() == 0) begin
      if (mismatches < 10) $display("beat %0d: status beat with nothing outstanding", beats_seen);
      mismatches++;
    end else begin
      want = pending_status.pop_front();
      cmp_field("tx_line", 8'(want.tx.tx_line), 8'(out_if.tx_line));
      cmp_field("tx_busy", 8'(want.tx.tx_busy), 8'(out_if.tx_busy));
      cmp_field("tx_done", 8'(want.tx.tx_done), 8'(out_if.tx_done));
      cmp_field("rx_busy", 8'(want.rx.rx_busy), 8'(out_if.rx_busy));
      cmp_field("rx_done", 8'(want.rx.rx_done), 8'(out_if.rx_done));
      cmp_field("rx_expired", 8'(want.rx.rx_expired), 8'(out_if.rx_expired));
      cmp_field("rx_byte", want.rx.rx_byte, out_if.rx_byte);
    end
    beats_seen++;
  endtask

  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready) begin
      check_beat();
      stall_left = idle_on ? $urandom_range(0, 10) : 0;
    end else if (stall_left != 0) begin
      stall_left--;
    end
    sink_ready <= (stall_left == 0);
  end

  task automatic wait_for_results();
    in_if.valid <= 1'b0;
    while (pending_status.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [7:0] val);
    logic [7:0] eff;
    wait_for_results();
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data <= val;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    cfg_if.valid <= 1'b0;
    eff = (val == 8'd0) ? 8'd1 : val;
    case (idx)
      CFG_TX_BIT_TIME:   model_regs.tx_bit_time = eff;
      CFG_RX_BIT_TIME:   model_regs.rx_bit_time = eff;
      CFG_RX_FIRST_TIME: model_regs.rx_first_sample_time = eff;
      CFG_IDLE_POLL:     model_regs.idle_poll_time = eff;
      default: ;
    endcase
  endtask

  task automatic send_tick(input tick_t tk, input bit typed, input line_status_t want);
    int unsigned gap;
    line_status_t model_st;
    gap = idle_on ? $urandom_range(0, 10) : 0;
    if (gap != 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.tx_start <= tk.tx_start;
    in_if.tx_value <= tk.tx_value;
    in_if.rx_start <= tk.rx_start;
    in_if.rx_poll_limit <= tk.rx_poll_limit;
    in_if.rx_line <= tk.rx_line;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    model_st = advance_tick(tk);
    pending_status.push_back(typed ? want : model_st);
    ticks_sent++;
  endtask

  task automatic make_tick(output tick_t tk);
    logic [7:0] frame_byte;
    int unsigned bit_len;
    tk.tx_start = ($urandom_range(0, 9) < 2);
    tk.tx_value = 8'($urandom);
    tk.rx_start = ($urandom_range(0, 9) < (rx_act ? 1 : 4));
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5, 6: tk.rx_poll_limit = 16'($urandom_range(0, 40));
      7:                   tk.rx_poll_limit = 16'($urandom);
      8:                   tk.rx_poll_limit = 16'hFFFF;
      default:             tk.rx_poll_limit = 16'h0000;
    endcase
    if (loopback) begin
      tk.rx_line = last_tx_line;
    end else begin
      if (line_q.size() == 0) begin
        if ($urandom_range(0, 9) < 7) begin
          // well-formed 8N1 frame at the receive bit time
          bit_len = 32'(model_regs.rx_bit_time);
          frame_byte = 8'($urandom);
          repeat ($urandom_range(0, 6)) line_q.push_back(1'b1);
          repeat (bit_len) line_q.push_back(1'b0);
          for (int i = 0; i < 8; i++) repeat (bit_len) line_q.push_back(frame_byte[i]);
          repeat (bit_len) line_q.push_back(1'b1);
        end else begin
          repeat ($urandom_range(1, 8)) line_q.push_back(1'($urandom_range(0, 1)));
        end
      end
      tk.rx_line = line_q.pop_front();
    end
  endtask

  task automatic set_phase(input int unsigned ph);
    logic [7:0] tx_t, rxb_t, first_t, poll_t;
    case (ph)
      1: begin
        tx_t = 8'd1; rxb_t = 8'd1; first_t = 8'd1; poll_t = 8'd1;
      end
      3: begin
        tx_t = 8'd255; rxb_t = 8'd255; first_t = 8'd255; poll_t = 8'd255;
      end
      4: begin
        tx_t = 8'd0; rxb_t = 8'd0; first_t = 8'd0; poll_t = 8'd0;
      end
      default: begin
        tx_t = 8'($urandom_range(1, 6));
        rxb_t = (ph % 3 == 2) ? tx_t : 8'($urandom_range(1, 6));
        first_t = rxb_t + rxb_t / 2;
        poll_t = 8'($urandom_range(1, 3));
      end
    endcase
    loopback = (ph % 3 == 2);
    idle_on = (ph != 5);
    line_q.delete();
    write_reg(CFG_TX_BIT_TIME, tx_t);
    write_reg(CFG_RX_BIT_TIME, rxb_t);
    write_reg(CFG_RX_FIRST_TIME, first_t);
    write_reg(CFG_IDLE_POLL, poll_t);
    settings_used++;
  endtask

  initial begin
    #5_000_000;
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    int unsigned ph;
    int unsigned k;
    tick_t tk;
    rst_n = 1'b0;
    in_if.valid = 1'b0;
    in_if.tx_start = 1'b0;
    in_if.tx_value = 8'h00;
    in_if.rx_start = 1'b0;
    in_if.rx_poll_limit = 16'h0000;
    in_if.rx_line = 1'b1;
    cfg_if.valid = 1'b0;
    cfg_if.index = CFG_TX_BIT_TIME;
    cfg_if.data = 8'h00;
    idle_on = 1'b1;
    loopback = 1'b0;
    reset_model();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[r]) begin
      if (directed_rows[r].kind == ROW_REG)
        write_reg(directed_rows[r].reg_idx, directed_rows[r].reg_val);
      else
        send_tick(directed_rows[r].tk, directed_rows[r].typed, directed_rows[r].want);
    end

    for (ph = 0; ph < 8; ph++) begin
      set_phase(ph);
      for (k = 0; k < 92; k++) begin
        make_tick(tk);
        send_tick(tk, 1'b0, ST_QUIET);
        if (ph == 2 && k == 45) wait_for_results();
      end
    end
    wait_for_results();

    $display("Ran %0d ticks under %0d register settings, %0d status beats checked.",
             ticks_sent, settings_used, beats_seen);
    $display("Bytes sent %0d, bytes received %0d, receive timeouts %0d, mismatches %0d.",
             bytes_sent, bytes_received, rx_timeouts, mismatches);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

/* files.f */
sv/bbu_pkg.sv
sv/bbu_if.sv
sv/bbu_tx.sv
sv/bbu_rx.sv
sv/bitbang_uart_8n1_with_poll_timeout.sv
verif/tb_bitbang_uart_8n1_with_poll_timeout.sv
